[src/bspc_pkg.sv]
// Shared types and codes of the biphasic stimulation pulse controller.
package bspc_pkg;

    // Item kinds carried on the input tuser
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_WEIGHT   = 3'd1;
    localparam logic [2:0] KIND_RESIDUAL = 3'd2;
    localparam logic [2:0] KIND_REQUEST  = 3'd3;
    localparam logic [2:0] KIND_FLOOR    = 3'd4;
    localparam logic [2:0] KIND_CEILING  = 3'd5;
    localparam logic [2:0] KIND_TRIGGER  = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [1:0] CFG_GAP          = 2'd1;
    localparam logic [1:0] CFG_MIN_WIDTH    = 2'd2;

    // Configuration reset values
    localparam logic [19:0] FRAME_PERIOD_RST = 20'd28571;
    localparam logic [7:0]  GAP_RST          = 8'd4;
    localparam logic [9:0]  MIN_WIDTH_RST    = 10'd10;

    // Timing configuration as seen by the pulse sequencer
    typedef struct packed {
        logic [19:0] frame_period;
        logic [7:0]  gap;
        logic [9:0]  min_width;
    } cfg_t;

    // Drive levels reported for one word
    typedef struct packed {
        logic phase_a;
        logic phase_b;
    } drive_t;

endpackage

[src/biphasic_stim_pulse_controller.sv]
// Top level of the biphasic stimulation pulse controller.
//
// Input stream: s_tuser carries the item kind (tick, weight, residual,
// requested width, minimum width, maximum width, trigger), s_tdata the
// 16-bit update value. A tick stands for one microsecond of pulse timing.
// Output stream: one word per input word with the phase A and phase B drive
// levels, the commanded width and the closed-loop flag after that item.
// Configuration: cfg_index selects frame period (0), gap (1) or minimum
// active width (2); cfg_data carries the value; cfg_ready is always high.
// Write configuration only while no word is in flight.
// The output word is registered and valid in the cycle after input accept.
// One word is taken every cycle unless the receiver stalls; the whole update
// of width and phase state completes in the cycle of acceptance, so the next word may follow at once.
// A single output register decouples the sides: while the receiver stalls,
// the held word stays on m_tdata and s_tready drops until it is taken.
// Reset clears all control values, the timers and the output register, sets
// open loop and loads the default frame period, gap and minimum width.
module biphasic_stim_pulse_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] phase_a, [1] phase_b, [17:2] width_now,
                                   // [18] closed_loop, [23:19] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    bspc_pkg::cfg_t   cfg_reg;
    bspc_pkg::drive_t drive;
    logic             accept;
    logic             tick;
    logic [15:0]      width_cmd;
    logic             closed_next;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign tick      = accept && (s_tuser == bspc_pkg::KIND_TICK);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_period <= bspc_pkg::FRAME_PERIOD_RST;
            cfg_reg.gap          <= bspc_pkg::GAP_RST;
            cfg_reg.min_width    <= bspc_pkg::MIN_WIDTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bspc_pkg::CFG_FRAME_PERIOD: cfg_reg.frame_period <= cfg_data;
                bspc_pkg::CFG_GAP:          cfg_reg.gap          <= cfg_data[7:0];
                bspc_pkg::CFG_MIN_WIDTH:    cfg_reg.min_width    <= cfg_data[9:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    bspc_width u_width (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (s_tuser),
        .value       (s_tdata),
        .width_cmd   (width_cmd),
        .closed_next (closed_next)
    );

    bspc_pulse u_pulse (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .width_cmd (width_cmd),
        .cfg       (cfg_reg),
        .drive     (drive)
    );

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 24'd0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {5'd0, closed_next, width_cmd, drive.phase_b, drive.phase_a};
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

endmodule

[src/bspc_width.sv]
// Control value registers and commanded width computation.
module bspc_width (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [2:0]  kind,
    input  logic [15:0] value,
    output logic [15:0] width_cmd,
    output logic        closed_next
);

    logic [15:0] weight_reg,   weight_next;
    logic [15:0] residual_reg, residual_next;
    logic [15:0] request_reg,  request_next;
    logic [15:0] floor_reg,    floor_next;
    logic [15:0] ceiling_reg,  ceiling_next;
    logic        closed_reg;
    logic [15:0] peak_reg,     peak_next;

    logic signed [16:0] diff;
    logic signed [16:0] half;
    logic [16:0]        cand_sum;
    logic [15:0]        cand;
    logic [15:0]        pk_lo;
    logic [15:0]        pk;

    // Apply the value update carried by this word
    always_comb
    begin
        weight_next   = weight_reg;
        residual_next = residual_reg;
        request_next  = request_reg;
        floor_next    = floor_reg;
        ceiling_next  = ceiling_reg;
        closed_next   = closed_reg;
        case (kind)
            bspc_pkg::KIND_WEIGHT:   weight_next   = value;
            bspc_pkg::KIND_RESIDUAL: residual_next = value;
            bspc_pkg::KIND_REQUEST:  request_next  = value;
            bspc_pkg::KIND_FLOOR:    floor_next    = value;
            bspc_pkg::KIND_CEILING:  ceiling_next  = value;
            bspc_pkg::KIND_TRIGGER:  closed_next   = (value != 16'd0);
            default:                 closed_next   = closed_reg;
        endcase
    end

    // Closed loop candidate: floor plus half the weight difference, clamped
    always_comb
    begin
        diff     = $signed({1'b0, weight_next}) - $signed({1'b0, residual_next});
        half     = diff >>> 1;
        cand_sum = {1'b0, floor_next} + {1'b0, half[15:0]};
        if (half[16])
            cand = floor_next;
        else if (cand_sum > {1'b0, ceiling_next})
            cand = ceiling_next;
        else
            cand = cand_sum[15:0];
        if (half[16] && (floor_next > ceiling_next))
            cand = ceiling_next;
        pk_lo = (peak_reg < floor_next) ? floor_next : peak_reg;
        pk    = (pk_lo > ceiling_next) ? ceiling_next : pk_lo;
        if (cand > pk)
            pk = cand;
    end

    // Open loop uses the request and drops the held peak
    always_comb
    begin
        if (closed_next)
        begin
            peak_next = pk;
            width_cmd = pk;
        end
        else
        begin
            peak_next = 16'd0;
            width_cmd = request_next;
        end
    end

    // Hold the control values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg   <= 16'd0;
            residual_reg <= 16'd0;
            request_reg  <= 16'd0;
            floor_reg    <= 16'd0;
            ceiling_reg  <= 16'd0;
            closed_reg   <= 1'b0;
            peak_reg     <= 16'd0;
        end
        else if (accept)
        begin
            weight_reg   <= weight_next;
            residual_reg <= residual_next;
            request_reg  <= request_next;
            floor_reg    <= floor_next;
            ceiling_reg  <= ceiling_next;
            closed_reg   <= closed_next;
            peak_reg     <= peak_next;
        end
    end

endmodule

[src/bspc_pulse.sv]
// Frame timer and biphasic pulse phase sequencer.
module bspc_pulse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic [15:0]      width_cmd,
    input  bspc_pkg::cfg_t   cfg,
    output bspc_pkg::drive_t drive
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_A    = 3'd1;
    localparam logic [2:0] PH_GAP1 = 3'd2;
    localparam logic [2:0] PH_B    = 3'd3;
    localparam logic [2:0] PH_GAP2 = 3'd4;

    logic [19:0] frame_timer_reg, frame_timer_next;
    logic [2:0]  phase_reg,       phase_next;
    logic [15:0] phase_timer_reg, phase_timer_next;
    logic [15:0] latched_reg,     latched_next;

    logic [19:0] two_gap;
    logic [19:0] fit_span;
    logic [18:0] fit;
    logic [15:0] fitted;
    logic [15:0] timer_dec;
    logic [20:0] frame_inc;

    // Width that fits the frame
    always_comb
    begin
        two_gap  = {11'd0, cfg.gap, 1'b0};
        fit_span = cfg.frame_period - two_gap;
        fit      = (cfg.frame_period > two_gap) ? fit_span[19:1] : 19'd0;
        fitted   = ({3'd0, width_cmd} > fit) ? fit[15:0] : width_cmd;
    end

    // Advance frame and phase on each tick
    always_comb
    begin
        timer_dec        = (phase_timer_reg != 16'd0) ? phase_timer_reg - 16'd1 : 16'd0;
        frame_inc        = {1'b0, frame_timer_reg} + 21'd1;
        frame_timer_next = frame_timer_reg;
        phase_next       = phase_reg;
        phase_timer_next = phase_timer_reg;
        latched_next     = latched_reg;
        if (tick)
        begin
            frame_timer_next = (frame_inc >= {1'b0, cfg.frame_period}) ? 20'd0
                                                                      : frame_inc[19:0];
            if (frame_timer_reg == 20'd0)
            begin
                latched_next = fitted;
                if ((fitted != 16'd0) && (fitted >= {6'd0, cfg.min_width}))
                begin
                    phase_next       = PH_A;
                    phase_timer_next = fitted;
                end
                else
                begin
                    phase_next       = PH_IDLE;
                    phase_timer_next = 16'd0;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                phase_timer_next = timer_dec;
                if (timer_dec == 16'd0)
                begin
                    // Move on, skipping a zero-length gap
                    case (phase_reg)
                        PH_A:
                        begin
                            if (cfg.gap != 8'd0)
                            begin
                                phase_next       = PH_GAP1;
                                phase_timer_next = {8'd0, cfg.gap};
                            end
                            else
                            begin
                                phase_next       = PH_B;
                                phase_timer_next = latched_reg;
                            end
                        end
                        PH_GAP1:
                        begin
                            phase_next       = PH_B;
                            phase_timer_next = latched_reg;
                        end
                        PH_B:
                        begin
                            if (cfg.gap != 8'd0)
                            begin
                                phase_next       = PH_GAP2;
                                phase_timer_next = {8'd0, cfg.gap};
                            end
                            else
                            begin
                                phase_next       = PH_IDLE;
                                phase_timer_next = 16'd0;
                            end
                        end
                        default:
                        begin
                            phase_next       = PH_IDLE;
                            phase_timer_next = 16'd0;
                        end
                    endcase
                end
            end
        end
    end

    assign drive.phase_a = (phase_next == PH_A);
    assign drive.phase_b = (phase_next == PH_B);

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_timer_reg <= 20'd0;
            phase_reg       <= PH_IDLE;
            phase_timer_reg <= 16'd0;
            latched_reg     <= 16'd0;
        end
        else
        begin
            frame_timer_reg <= frame_timer_next;
            phase_reg       <= phase_next;
            phase_timer_reg <= phase_timer_next;
            latched_reg     <= latched_next;
        end
    end

endmodule

[tb/tb_biphasic_stim_pulse_controller.sv]
// Self-checking stream testbench for the biphasic stimulation pulse controller.
`timescale 1ns / 1ps

module tb_biphasic_stim_pulse_controller;

    // Spare kind code: the block must leave its state alone
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENT_WORDS = 110;

    // Sequencer phases of the pulse generator
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_A,
        SEQ_GAP1,
        SEQ_B,
        SEQ_GAP2
    } seq_phase_t;

    // One output word, phase_a in the lowest bit
    typedef struct packed {
        logic        closed;
        logic [15:0] width;
        logic        phase_b;
        logic        phase_a;
    } drive_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] value
    logic [2:0]  s_tuser;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [0] phase_a, [1] phase_b, [17:2] width_now,
                            // [18] closed_loop, [23:19] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;

    // Timing registers as the block should hold them
    logic [19:0] period_q;
    logic [7:0]  gap_q;
    logic [9:0]  min_width_q;

    // Control values and sequencer state of the pulse predictor
    logic [15:0] weight_q;
    logic [15:0] residual_q;
    logic [15:0] request_q;
    logic [15:0] floor_q;
    logic [15:0] ceiling_q;
    logic [15:0] peak_q;
    logic [15:0] latched_q;
    logic [15:0] phase_left;
    logic [19:0] frame_count;
    logic        closed_q;
    seq_phase_t  phase_q;

    drive_word_t expected_drive[$];

    int error_count;
    int cycle_count;
    int words_checked;
    int ticks_taken;
    int pulses_started;
    int closed_words;
    int reg_writes;
    int src_idle_pct;
    int sink_stall_pct;

    biphasic_stim_pulse_controller dut (.*);

    // Clock, 20 ns period
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                     expected_drive.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver stall pattern, changed at the falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    task automatic reset_predictor();
        period_q = bspc_pkg::FRAME_PERIOD_RST;
        gap_q = bspc_pkg::GAP_RST;
        min_width_q = bspc_pkg::MIN_WIDTH_RST;
        weight_q = '0;
        residual_q = '0;
        request_q = '0;
        floor_q = '0;
        ceiling_q = '0;
        peak_q = '0;
        latched_q = '0;
        phase_left = '0;
        frame_count = '0;
        closed_q = 1'b0;
        phase_q = SEQ_IDLE;
    endtask

    // Advance the frame and pulse timers by one microsecond
    task automatic advance_microsecond(input logic [15:0] width);
        int fit;
        if (frame_count == '0)
        begin
            fit = (int'(period_q) > 2 * int'(gap_q))
                  ? (int'(period_q) - 2 * int'(gap_q)) / 2 : 0;
            latched_q = (int'(width) > fit) ? fit[15:0] : width;
            if (latched_q != '0 && latched_q >= min_width_q)
            begin
                phase_q = SEQ_A;
                phase_left = latched_q;
                pulses_started++;
            end
            else
            begin
                phase_q = SEQ_IDLE;
                phase_left = '0;
            end
        end
        else if (phase_q != SEQ_IDLE)
        begin
            if (phase_left != '0)
                phase_left--;
            // Skip every phase whose time is used up, zero-length gaps included
            for (int step = 0; step < 5 && phase_q != SEQ_IDLE && phase_left == '0; step++)
            begin
                case (phase_q)
                    SEQ_A:
                    begin
                        phase_q = SEQ_GAP1;
                        phase_left = 16'(gap_q);
                    end
                    SEQ_GAP1:
                    begin
                        phase_q = SEQ_B;
                        phase_left = latched_q;
                    end
                    SEQ_B:
                    begin
                        phase_q = SEQ_GAP2;
                        phase_left = 16'(gap_q);
                    end
                    default:
                    begin
                        phase_q = SEQ_IDLE;
                        phase_left = '0;
                    end
                endcase
            end
        end
        frame_count = (int'(frame_count) + 1 >= int'(period_q)) ? '0 : frame_count + 20'd1;
    endtask

    // Apply one input word and queue the drive word it must produce
    task automatic predict_drive(input logic [2:0] kind, input logic [15:0] value);
        int diff;
        int cand;
        int held;
        logic [15:0] width;
        drive_word_t word;
        case (kind)
            bspc_pkg::KIND_WEIGHT:   weight_q = value;
            bspc_pkg::KIND_RESIDUAL: residual_q = value;
            bspc_pkg::KIND_REQUEST:  request_q = value;
            bspc_pkg::KIND_FLOOR:    floor_q = value;
            bspc_pkg::KIND_CEILING:  ceiling_q = value;
            bspc_pkg::KIND_TRIGGER:  closed_q = (value != '0);
            default:                 ;
        endcase
        if (!closed_q)
        begin
            peak_q = '0;
            width = request_q;
        end
        else
        begin
            // Half the weight loss, rounded toward minus infinity
            diff = int'(weight_q) - int'(residual_q);
            cand = int'(floor_q) + (diff >>> 1);
            if (cand < int'(floor_q))
                cand = int'(floor_q);
            if (cand > int'(ceiling_q))
                cand = int'(ceiling_q);
            // Hold the peak inside the current limits, then raise it
            held = int'(peak_q);
            if (held < int'(floor_q))
                held = int'(floor_q);
            if (held > int'(ceiling_q))
                held = int'(ceiling_q);
            if (cand > held)
                held = cand;
            peak_q = held[15:0];
            width = peak_q;
            closed_words++;
        end
        if (kind == bspc_pkg::KIND_TICK)
        begin
            ticks_taken++;
            advance_microsecond(width);
        end
        word.phase_a = (phase_q == SEQ_A);
        word.phase_b = (phase_q == SEQ_B);
        word.width = width;
        word.closed = closed_q;
        expected_drive.push_back(word);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field,
                     want, got);
        end
    endtask

    task automatic check_drive(input logic [23:0] word);
        drive_word_t want;
        if (expected_drive.size() == 0)
        begin
            error_count++;
            $display("%0t ns: output word %h with none expected", $time, word);
        end
        else
        begin
            want = expected_drive.pop_front();
            words_checked++;
            compare_field("phase_a", want.phase_a, word[0]);
            compare_field("phase_b", want.phase_b, word[1]);
            compare_field("width_now", want.width, word[17:2]);
            compare_field("closed_loop", want.closed, word[18]);
        end
    endtask

    // Sample all handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_drive(m_tdata);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bspc_pkg::CFG_FRAME_PERIOD: period_q = cfg_data;
                    bspc_pkg::CFG_GAP:          gap_q = cfg_data[7:0];
                    bspc_pkg::CFG_MIN_WIDTH:    min_width_q = cfg_data[9:0];
                    default:                    ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_drive(s_tuser, s_tdata);
        end
    end

    // Send one word; called and returning at a falling edge
    task automatic send_word(input logic [2:0] kind, input logic [15:0] value);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the input until every expected word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_drive.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [19:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(negedge clk);
    endtask

    // Width law: open loop, closed loop, peak hold, limits, spare kind
    task automatic test_width_law();
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, 20'd20);
        write_reg(bspc_pkg::CFG_GAP, 20'd0);
        write_reg(bspc_pkg::CFG_MIN_WIDTH, 20'd1);
        send_word(bspc_pkg::KIND_REQUEST, 16'hFFFF);
        send_word(KIND_UNUSED, 16'hFFFF);
        send_word(bspc_pkg::KIND_TICK, 16'h0000);
        send_word(bspc_pkg::KIND_TRIGGER, 16'h8000);
        send_word(bspc_pkg::KIND_WEIGHT, 16'hFFFF);
        send_word(bspc_pkg::KIND_CEILING, 16'hFFFF);
        send_word(bspc_pkg::KIND_RESIDUAL, 16'hFFFF);
        send_word(bspc_pkg::KIND_WEIGHT, 16'h0000);
        send_word(bspc_pkg::KIND_RESIDUAL, 16'h0003);
        send_word(bspc_pkg::KIND_FLOOR, 16'd40000);
        // Ceiling below floor: the ceiling wins
        send_word(bspc_pkg::KIND_CEILING, 16'd100);
        send_word(bspc_pkg::KIND_TRIGGER, 16'h0000);
        send_word(bspc_pkg::KIND_TRIGGER, 16'h0001);
    endtask

    // Frame timing: short periods, wrap on a lowered period, gap edits, idle frames
    task automatic test_frame_timing();
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, 20'd1);
        send_word(bspc_pkg::KIND_TICK, 16'h0000);
        send_word(bspc_pkg::KIND_TICK, 16'hFFFF);
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, 20'd0);
        send_word(bspc_pkg::KIND_TICK, 16'h5555);
        // Full pulse with the gap removed while phase A runs
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, 20'd12);
        write_reg(bspc_pkg::CFG_GAP, 20'd2);
        write_reg(bspc_pkg::CFG_MIN_WIDTH, 20'd2);
        send_word(bspc_pkg::KIND_TRIGGER, 16'h0000);
        send_word(bspc_pkg::KIND_REQUEST, 16'd3);
        repeat (2) send_word(bspc_pkg::KIND_TICK, 16'h0000);
        write_reg(bspc_pkg::CFG_GAP, 20'd0);
        repeat (5) send_word(bspc_pkg::KIND_TICK, 16'h0000);
        // Width below the minimum gives an idle frame
        write_reg(bspc_pkg::CFG_MIN_WIDTH, 20'd1023);
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, 20'd8);
        repeat (2) send_word(bspc_pkg::KIND_TICK, 16'h0000);
        // Wrap the timer, then start a frame at the largest settings
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, 20'd1);
        send_word(bspc_pkg::KIND_TICK, 16'h0000);
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, 20'hFFFFF);
        write_reg(bspc_pkg::CFG_GAP, 20'd255);
        write_reg(bspc_pkg::CFG_MIN_WIDTH, 20'd0);
        repeat (2) send_word(bspc_pkg::KIND_TICK, 16'h0000);
    endtask

    task automatic pick_timing();
        logic [19:0] period;
        logic [19:0] gap;
        logic [19:0] min_width;
        case ($urandom_range(0, 9))
            0:       period = 20'd1000;
            1:       period = 20'($urandom_range(0, 3));
            default: period = 20'($urandom_range(4, 90));
        endcase
        gap = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 255))
                                          : 20'($urandom_range(0, 6));
        min_width = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 1023))
                                                : 20'($urandom_range(0, 12));
        write_reg(bspc_pkg::CFG_FRAME_PERIOD, period);
        write_reg(bspc_pkg::CFG_GAP, gap);
        write_reg(bspc_pkg::CFG_MIN_WIDTH, min_width);
    endtask

    // Mostly ticks so frames run, mixed with updates of small and full-range values
    task automatic send_random_word();
        int pick;
        logic [2:0] kind;
        logic [15:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            kind = bspc_pkg::KIND_TICK;
        else if (pick < 68)
            kind = bspc_pkg::KIND_WEIGHT;
        else if (pick < 74)
            kind = bspc_pkg::KIND_RESIDUAL;
        else if (pick < 79)
            kind = bspc_pkg::KIND_REQUEST;
        else if (pick < 84)
            kind = bspc_pkg::KIND_FLOOR;
        else if (pick < 89)
            kind = bspc_pkg::KIND_CEILING;
        else if (pick < 97)
            kind = bspc_pkg::KIND_TRIGGER;
        else
            kind = KIND_UNUSED;
        if ($urandom_range(0, 3) == 0)
            value = 16'($urandom_range(0, 65535));
        else
            value = 16'($urandom_range(0, 48));
        if (kind == bspc_pkg::KIND_TRIGGER && $urandom_range(0, 2) == 0)
            value = '0;
        send_word(kind, value);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        repeat (3)
        begin
            pick_timing();
            repeat (SEGMENT_WORDS) send_random_word();
        end
    endtask

    task automatic finish_run();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Checked %0d output words: %0d ticks, %0d pulses started",
                 words_checked, ticks_taken, pulses_started);
        $display("%0d closed-loop words, %0d register writes, %0d mismatches, %0d cycles",
                 closed_words, reg_writes, error_count, cycle_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = bspc_pkg::KIND_TICK;
        cfg_valid = 1'b0;
        cfg_index = bspc_pkg::CFG_FRAME_PERIOD;
        cfg_data = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        words_checked = 0;
        ticks_taken = 0;
        pulses_started = 0;
        closed_words = 0;
        reg_writes = 0;
        reset_predictor();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_width_law();
        test_frame_timing();
        test_random_traffic(35, 66);
        test_random_traffic(66, 35);
        test_random_traffic(0, 0);
        finish_run();
    end

endmodule
